// ----- design/sgcw_pkg.sv -----
// shared types and constants for the sobol gray-code word block
`timescale 1ns / 1ps

package sgcw_pkg;

    // item field widths
    localparam int CMD_W    = 1;
    localparam int DIM_W    = 10;
    localparam int BIT_W    = 6;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 1;

    // compare widths, one bit wider so the largest table size fits
    localparam int DIM_CMP_W = DIM_W + 1;
    localparam int BIT_CMP_W = BIT_W + 1;

    // request tdata layout, lowest field first
    localparam int DIM_LSB   = 0;
    localparam int BIT_LSB   = DIM_LSB + DIM_W;
    localparam int VALUE_LSB = BIT_LSB + BIT_W;
    localparam int INDEX_LSB = VALUE_LSB + WORD_W;
    localparam int S_FIELD_W = INDEX_LSB + WORD_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

    // result tdata holds the word alone
    localparam int M_TDATA_W = ((WORD_W + 7) / 8) * 8;

    // xor reduction fan-in of the first pipeline stage
    localparam int GROUP_SIZE = 8;

    // request kind carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 1'b0,
        CMD_COMPUTE = 1'b1
    } t_cmd;

    // result status carried in tuser
    localparam logic [STATUS_W-1:0] STATUS_OK      = 1'b0;
    localparam logic [STATUS_W-1:0] STATUS_DIM_ERR = 1'b1;

    // control travelling alongside the direction words
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } t_stage_ctl;

endpackage

// ----- design/sgcw_xor_reduce.sv -----
// two-stage registered xor tree over the direction words selected by the gray code
`timescale 1ns / 1ps

module sgcw_xor_reduce
    import sgcw_pkg::*;
#(
    parameter int DIRECTION_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage_ctl          i_ctl,
    output logic                o_ready,
    input  logic [DIRECTION_BITS-1:0] i_gray,
    input  logic [WORD_W-1:0]   i_words [DIRECTION_BITS],
    output logic                o_valid,
    input  logic                i_ready,
    output logic [WORD_W-1:0]   o_word,
    output logic [STATUS_W-1:0] o_status
);

    localparam int GROUPS = (DIRECTION_BITS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD    = GROUPS * GROUP_SIZE;

    logic                r2_valid;
    logic [STATUS_W-1:0] r2_status;
    logic [WORD_W-1:0]   r2_part [GROUPS];
    logic                r3_valid;
    logic [STATUS_W-1:0] r3_status;
    logic [WORD_W-1:0]   r3_word;

    logic                w_adv2;
    logic                w_adv3;
    logic [WORD_W-1:0]   w_masked [PAD];
    logic [WORD_W-1:0]   n2_part [GROUPS];
    logic [WORD_W-1:0]   n3_word;

    // a stage moves when it is empty or the one after it moves
    assign w_adv3  = !r3_valid || i_ready;
    assign w_adv2  = !r2_valid || w_adv3;
    assign o_ready = w_adv2;

    // keep a word only where its gray bit is set, pad to whole groups
    for (genvar i = 0; i < PAD; i++) begin : g_mask
        if (i < DIRECTION_BITS) begin : g_live
            assign w_masked[i] = i_words[i] & {WORD_W{i_gray[i]}};
        end else begin : g_pad
            assign w_masked[i] = '0;
        end
    end

    // first level: xor within each group
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n2_part[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                n2_part[g] = n2_part[g] ^ w_masked[g * GROUP_SIZE + k];
            end
        end
    end

    // second level: xor across groups
    always_comb begin
        n3_word = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n3_word = n3_word ^ r2_part[g];
        end
    end

    // stage two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv2) begin
            r2_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_status <= i_ctl.status;
            r2_part   <= n2_part;
        end
    end

    // stage three is the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r3_status <= r2_status;
            r3_word   <= n3_word;
        end
    end

    assign o_valid  = r3_valid;
    assign o_word   = r3_word;
    assign o_status = r3_status;

endmodule

// ----- design/sobol_gray_code_word.sv -----
// sobol word for one point index: direction store, gray coding and xor pipeline
//
//  channel  | dir | handshake             | carries
//  ---------+-----+-----------------------+----------------------------------------------
//  request  | in  | i_s_tvalid/o_s_tready | tuser: cmd; tdata: dimension, bit_position,
//           |     |                       |   direction_value, point_index
//  result   | out | o_m_tvalid/i_m_tready | tuser: status; tdata: word
//
// one request enters per clock while o_s_tready is high; its result passes through the memory
// read stage, the group xor stage and the final xor and output register
// after reset a clearing pass writes zero to the direction store, one dimension row
// across all bit banks per cycle, with o_s_tready low
// a stalled result freezes only the stages that hold data, bubbles fill in behind it
`timescale 1ns / 1ps

module sobol_gray_code_word
    import sgcw_pkg::*;
#(
    parameter int DIMENSIONS     = 64,
    parameter int DIRECTION_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // dimension, bit_position, direction_value, point_index (lowest bit up)
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // cmd
    input  logic [CMD_W-1:0]     i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // word
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // status
    output logic [STATUS_W-1:0]  o_m_tuser
);

    localparam int DIM_AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

    logic                      r_clr_busy;
    logic [DIM_AW-1:0]         r_clr_addr;
    logic                      n_clr_busy;
    logic [DIM_AW-1:0]         n_clr_addr;

    logic                      r1_valid;
    logic [STATUS_W-1:0]       r1_status;
    logic [DIRECTION_BITS-1:0] r1_gray;
    logic [WORD_W-1:0]         r1_words [DIRECTION_BITS];

    t_cmd                      w_cmd;
    logic [DIM_W-1:0]          w_dim;
    logic [BIT_W-1:0]          w_bit;
    logic [WORD_W-1:0]         w_value;
    logic [WORD_W-1:0]         w_index;
    logic [WORD_W-1:0]         w_gray;
    logic                      w_dim_ok;
    logic                      w_bit_ok;
    logic                      w_accept;
    logic                      w_load_we;
    logic                      w_adv1;
    logic                      w_adv2;
    logic [DIM_AW-1:0]         w_rd_addr;
    logic [DIM_AW-1:0]         w_wr_addr;
    logic [WORD_W-1:0]         w_wr_data;
    t_stage_ctl                w_ctl1;
    logic [WORD_W-1:0]         w_word;

    // request field unpacking
    assign w_cmd   = t_cmd'(i_s_tuser[0]);
    assign w_dim   = i_s_tdata[DIM_LSB +: DIM_W];
    assign w_bit   = i_s_tdata[BIT_LSB +: BIT_W];
    assign w_value = i_s_tdata[VALUE_LSB +: WORD_W];
    assign w_index = i_s_tdata[INDEX_LSB +: WORD_W];

    // range checks and gray coding
    assign w_dim_ok = ({1'b0, w_dim} < DIM_CMP_W'(DIMENSIONS));
    assign w_bit_ok = ({1'b0, w_bit} < BIT_CMP_W'(DIRECTION_BITS));
    assign w_gray   = w_index ^ (w_index >> 1);

    // handshake: the first stage moves when empty or when the tree takes it
    assign w_adv1     = !r1_valid || w_adv2;
    assign o_s_tready = w_adv1 && !r_clr_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load_we  = w_accept && w_dim_ok && w_bit_ok && (w_cmd == CMD_LOAD);

    // store addressing, the clearing pass owns the write port while busy
    assign w_rd_addr = w_dim_ok ? w_dim[DIM_AW-1:0] : '0;
    assign w_wr_addr = r_clr_busy ? r_clr_addr : w_rd_addr;
    assign w_wr_data = r_clr_busy ? '0 : w_value;

    // clearing pass sequencing
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            if (r_clr_addr == DIM_AW'(DIMENSIONS - 1)) begin
                n_clr_busy = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // one bank per direction bit, indexed by dimension, registered read
    for (genvar b = 0; b < DIRECTION_BITS; b++) begin : g_bank
        logic [WORD_W-1:0] r_mem [DIMENSIONS];
        logic              w_we;

        assign w_we = r_clr_busy || (w_load_we && (w_bit == BIT_W'(b)));

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_wr_addr] <= w_wr_data;
            end
            if (w_adv1) begin
                r1_words[b] <= r_mem[w_rd_addr];
            end
        end
    end

    // first stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv1) begin
            r1_valid <= w_accept;
        end
    end

    // loads and errors carry an empty gray mask, so their word comes out zero
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_status <= w_dim_ok ? STATUS_OK : STATUS_DIM_ERR;
            r1_gray   <= (w_dim_ok && (w_cmd == CMD_COMPUTE))
                       ? w_gray[DIRECTION_BITS-1:0] : '0;
        end
    end

    assign w_ctl1.valid  = r1_valid;
    assign w_ctl1.status = r1_status;

    // xor tree and output register
    sgcw_xor_reduce #(
        .DIRECTION_BITS (DIRECTION_BITS)
    ) u_reduce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl1),
        .o_ready  (w_adv2),
        .i_gray   (r1_gray),
        .i_words  (r1_words),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_word   (w_word),
        .o_status (o_m_tuser)
    );

    assign o_m_tdata = M_TDATA_W'(w_word);

    // no request is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_s_tready)
        else $error("request accepted during clearing pass");

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r1_valid)
        else $error("accepted request lost at first stage");

    // a held first stage keeps its item
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !w_adv2) |=> r1_valid)
        else $error("first stage dropped an item under stall");

    // a dimension error always comes with a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == STATUS_DIM_ERR)) |-> (o_m_tdata == '0))
        else $error("error result with nonzero word");

endmodule

// ----- verif/sgcw_checker.sv -----
// checker for the sobol gray-code word block: direction store model and result compare
`timescale 1ns / 1ps

module sgcw_checker
    import sgcw_pkg::*;
#(
    parameter int DIMENSIONS     = 64,
    parameter int DIRECTION_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // dimension, bit_position, direction_value, point_index (lowest bit up)
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // cmd
    input  logic [CMD_W-1:0]     i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // word
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    // status
    input  logic [STATUS_W-1:0]  i_m_tuser,
    output int                   o_fail_cnt,
    output int                   o_pending,
    output int                   o_loads,
    output int                   o_computes,
    output int                   o_dim_errors
);

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] status;
    } t_sobol_result;

    // model of the direction store, one row of words per dimension
    logic [WORD_W-1:0] dir_words [DIMENSIONS][DIRECTION_BITS];

    // results still owed by the block, oldest first
    t_sobol_result owed_results [$];

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch at %0t: %s, got %h, want %h", $realtime, what, got, want);
        o_fail_cnt++;
    endtask

    // apply one request to the store model and work out its result
    function automatic t_sobol_result predict_sobol(input t_cmd cmd,
                                                    input logic [S_TDATA_W-1:0] data);
        int                dim;
        int                slot;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] index;
        logic [WORD_W-1:0] gray;
        t_sobol_result     res;
        dim   = int'(data[DIM_LSB +: DIM_W]);
        slot  = int'(data[BIT_LSB +: BIT_W]);
        value = data[VALUE_LSB +: WORD_W];
        index = data[INDEX_LSB +: WORD_W];
        res.word   = '0;
        res.status = STATUS_OK;
        if (dim >= DIMENSIONS) begin
            res.status = STATUS_DIM_ERR;
        end else if (cmd == CMD_LOAD) begin
            if (slot < DIRECTION_BITS) begin
                dir_words[dim][slot] = value;
            end
        end else begin
            // gray bits beyond the stored slots add nothing
            gray = index ^ (index >> 1);
            for (int b = 0; b < WORD_W; b++) begin
                if (gray[b] && b < DIRECTION_BITS) begin
                    res.word ^= dir_words[dim][b];
                end
            end
        end
        return res;
    endfunction

    // results are compared before the request at the same edge is modelled
    always @(posedge i_clk) begin : monitor
        t_sobol_result want;
        if (!i_rst_n) begin
            foreach (dir_words[d, b]) begin
                dir_words[d][b] = '0;
            end
            owed_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result with nothing owed", i_m_tdata, '0);
                end else begin
                    want = owed_results.pop_front();
                    if (i_m_tdata[WORD_W-1:0] !== want.word) begin
                        report_mismatch("word", i_m_tdata[WORD_W-1:0], want.word);
                    end
                    if (i_m_tuser !== want.status) begin
                        report_mismatch("status", WORD_W'(i_m_tuser), WORD_W'(want.status));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = predict_sobol(t_cmd'(i_s_tuser), i_s_tdata);
                owed_results.push_back(want);
                if (want.status == STATUS_DIM_ERR) begin
                    o_dim_errors++;
                end else if (t_cmd'(i_s_tuser) == CMD_LOAD) begin
                    o_loads++;
                end else begin
                    o_computes++;
                end
            end
        end
        o_pending = owed_results.size();
    end

endmodule

// ----- verif/sobol_gray_code_word_tb.sv -----
// testbench top for the sobol gray-code word block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module sobol_gray_code_word_tb;
    import sgcw_pkg::*;

    localparam int DIMENSIONS     = 64;
    localparam int DIRECTION_BITS = 64;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 400000;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic [CMD_W-1:0]     i_s_tuser  = CMD_LOAD;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]  o_m_tuser;

    int fail_cnt;
    int pending;
    int loads;
    int computes;
    int dim_errors;
    int requests_sent = 0;
    int hold_seen     = 0;
    int cycle_cnt     = 0;

    sobol_gray_code_word #(
        .DIMENSIONS     (DIMENSIONS),
        .DIRECTION_BITS (DIRECTION_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    sgcw_checker #(
        .DIMENSIONS     (DIMENSIONS),
        .DIRECTION_BITS (DIRECTION_BITS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_loads      (loads),
        .o_computes   (computes),
        .o_dim_errors (dim_errors)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // offer one request and hold it until the block takes it
    task automatic send_request(input t_cmd cmd, input int dim, input int slot,
                                input logic [WORD_W-1:0] value,
                                input logic [WORD_W-1:0] index);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[DIM_LSB +: DIM_W]    = dim[DIM_W-1:0];
        data[BIT_LSB +: BIT_W]    = slot[BIT_W-1:0];
        data[VALUE_LSB +: WORD_W] = value;
        data[INDEX_LSB +: WORD_W] = index;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
        requests_sent++;
    endtask

    // receiver: random stall patterns, plus one long hold-off to back the block up
    initial begin : receiver
        int mode;
        int run_len;
        forever begin
            if (hold_seen == 0 && requests_sent >= HOLD_AFTER) begin
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    i_m_tready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_seen = HOLD_CYCLES;
            end else begin
                mode    = $urandom_range(0, 3);
                run_len = $urandom_range(1, 40);
                for (int k = 0; k < run_len; k++) begin
                    case (mode)
                        0: i_m_tready <= 1'b1;
                        1: i_m_tready <= 1'($urandom_range(0, 1));
                        2: i_m_tready <= ($urandom_range(0, 3) != 0);
                        default: i_m_tready <= ((k % 7) < 2);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    // sender: reset, directed requests, then random bursts
    initial begin : sender
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] index;
        t_cmd              cmd;
        int                dim;
        int                burst;
        int                gap;
        int                rand_sent;
        int                pick;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unloaded store gives zero
        send_request(CMD_COMPUTE, 0, 0, '0, '1);
        // loads at the lowest and highest slot, plus edge values
        send_request(CMD_LOAD, 0, 0, '1, '0);
        send_request(CMD_LOAD, 0, 63, 64'h8000_0000_0000_0001, '1);
        send_request(CMD_LOAD, 0, 1, 64'h5555_5555_5555_5555, '0);
        send_request(CMD_LOAD, 0, 62, 64'h0123_4567_89AB_CDEF, '0);
        send_request(CMD_LOAD, DIMENSIONS - 1, 31, {$urandom, $urandom}, '0);
        send_request(CMD_LOAD, DIMENSIONS - 1, 30, 64'hFEDC_BA98_7654_3210, '0);
        // out-of-range dimension on a load must not write
        send_request(CMD_LOAD, DIMENSIONS, 5, '1, '0);
        send_request(CMD_LOAD, 1023, 63, '1, '1);
        // computes: zero index, indices one and two, top bit, all ones
        send_request(CMD_COMPUTE, 0, 0, '0, 64'd0);
        send_request(CMD_COMPUTE, 0, 0, '0, 64'd1);
        send_request(CMD_COMPUTE, 0, 0, '0, 64'd2);
        send_request(CMD_COMPUTE, 0, 0, '0, '1);
        send_request(CMD_COMPUTE, 0, 0, '0, 64'h8000_0000_0000_0000);
        send_request(CMD_COMPUTE, DIMENSIONS - 1, 0, '0, 64'h0000_0000_8000_0000);
        // out-of-range dimension on a compute
        send_request(CMD_COMPUTE, DIMENSIONS, 0, '0, '1);
        send_request(CMD_COMPUTE, 1023, 63, '1, '1);
        // overwrite a slot, then read it back
        send_request(CMD_LOAD, 0, 0, '0, '0);
        send_request(CMD_COMPUTE, 0, 0, '0, 64'd1);
        send_request(CMD_LOAD, 5, 32, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_request(CMD_COMPUTE, 5, 0, '0, {$urandom, $urandom});
        send_request(CMD_COMPUTE, 5, 0, '0, 64'h0000_0001_0000_0000);

        // random bursts, mostly on a few dimensions so computes hit loaded words
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
            for (int k = 0; k < burst && rand_sent < RANDOM_ITEMS; k++) begin
                cmd  = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_COMPUTE;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    dim = $urandom_range(0, 3);
                end else if (pick < 85) begin
                    dim = $urandom_range(4, DIMENSIONS - 1);
                end else begin
                    dim = $urandom_range(DIMENSIONS, 1023);
                end
                case ($urandom_range(0, 9))
                    0: value = '0;
                    1: value = '1;
                    default: value = {$urandom, $urandom};
                endcase
                case ($urandom_range(0, 4))
                    0: index = {$urandom, $urandom};
                    1: index = 64'($urandom_range(0, 255));
                    2: index = 64'd1 << $urandom_range(0, 63);
                    3: index = '1;
                    default: index = {$urandom | 32'hC000_0000, $urandom};
                endcase
                send_request(cmd, dim, $urandom_range(0, 63), value, index);
                rand_sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        // let the checker log the last request, drain, then allow for the pipeline depth
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d loads, %0d computes and %0d out-of-range dimensions",
                 loads, computes, dim_errors);
        $display("output held off for %0d cycles in one stretch, %0d cycles overall",
                 hold_seen, cycle_cnt);
        if (fail_cnt == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
